@@ hdl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the pedestrian crossing controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int TIMER_BITS     = 16;
   localparam int REPEAT_BITS    = 8;
   localparam int TIME_BITS      = 16;
   localparam int COUNT_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TRANSITION_TIME = 3'd0,
      REG_AMBER_TIME      = 3'd1,
      REG_FLASH_HALF_TIME = 3'd2,
      REG_FLASH_COUNT     = 3'd3,
      REG_BEEP_ON_TIME    = 3'd4,
      REG_BEEP_GAP_TIME   = 3'd5,
      REG_BEEP_COUNT      = 3'd6,
      REG_HOLD_TIME       = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_REST      = 4'd0,
      PH_GREEN_OFF = 4'd1,
      PH_AMBER     = 4'd2,
      PH_GAP       = 4'd3,
      PH_RED       = 4'd4,
      PH_RED_CLEAR = 4'd5,
      PH_WALK      = 4'd6,
      PH_FLASH     = 4'd7,
      PH_CLEAR_A   = 4'd8,
      PH_CLEAR_B   = 4'd9,
      PH_HOLD      = 4'd10
   } phase_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  transition_time;
      logic [TIME_BITS-1:0]  amber_time;
      logic [TIME_BITS-1:0]  flash_half_time;
      logic [COUNT_BITS-1:0] flash_count;
      logic [TIME_BITS-1:0]  beep_on_time;
      logic [TIME_BITS-1:0]  beep_gap_time;
      logic [COUNT_BITS-1:0] beep_count;
      logic [TIME_BITS-1:0]  hold_time;
   } cfg_type;

   typedef struct packed {
      logic      green_lamp;
      logic      amber_lamp;
      logic      red_lamp;
      logic      walk_lamp;
      logic      dont_walk_lamp;
      logic      buzzer_on;
      logic      wait_lamp;
      phase_type phase_now;
   } lamps_type;

endpackage

@@ hdl/pedestrian_crossing_controller.sv @@
// ----------------------------------------------------------------------------
// pedestrian_crossing_controller
// Pelican-style crossing controller: one request per millisecond tick,
// one lamp/buzzer response per request.
// ----------------------------------------------------------------------------
// Each request carries the button level for one tick and produces exactly one
// response with every lamp level, the buzzer level and the phase number. A
// request is taken every clock cycle while the response register is empty or
// being drained; its response appears in that register on the next cycle.
// Phase timer, repeat counter and lamp decode feed the response register. The
// user is to write timing registers through the CSR port while no request is
// outstanding; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pedestrian_crossing_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_button,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_green_lamp,
   output logic                               rsp_amber_lamp,
   output logic                               rsp_red_lamp,
   output logic                               rsp_walk_lamp,
   output logic                               rsp_dont_walk_lamp,
   output logic                               rsp_buzzer_on,
   output logic                               rsp_wait_lamp,
   output logic [3:0]                         rsp_phase_now,
   input  logic                               csr_write_enable,
   input  logic [pcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pcc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   pcc_pkg::cfg_type   cfg;
   pcc_pkg::lamps_type lamps;
   pcc_pkg::lamps_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               step;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   pcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (pcc_pkg::csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pcc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .button (req_button),
      .cfg    (cfg),
      .lamps  (lamps)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (step) begin
         rsp_in       = lamps;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_green_lamp     = rsp_ff.green_lamp;
   assign rsp_amber_lamp     = rsp_ff.amber_lamp;
   assign rsp_red_lamp       = rsp_ff.red_lamp;
   assign rsp_walk_lamp      = rsp_ff.walk_lamp;
   assign rsp_dont_walk_lamp = rsp_ff.dont_walk_lamp;
   assign rsp_buzzer_on      = rsp_ff.buzzer_on;
   assign rsp_wait_lamp      = rsp_ff.wait_lamp;
   assign rsp_phase_now      = rsp_ff.phase_now;

endmodule

@@ hdl/pcc_csr.sv @@
// ----------------------------------------------------------------------------
// pcc_csr
// Timing and count registers, written through the plain CSR port.
// ----------------------------------------------------------------------------
module pcc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  pcc_pkg::csr_index_type             csr_index,
   input  logic [pcc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output pcc_pkg::cfg_type                   cfg
);

   pcc_pkg::cfg_type cfg_ff;
   pcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pcc_pkg::REG_TRANSITION_TIME: begin
               cfg_in.transition_time = csr_write_data[pcc_pkg::TIME_BITS-1:0];
            end
            pcc_pkg::REG_AMBER_TIME: begin
               cfg_in.amber_time = csr_write_data[pcc_pkg::TIME_BITS-1:0];
            end
            pcc_pkg::REG_FLASH_HALF_TIME: begin
               cfg_in.flash_half_time = csr_write_data[pcc_pkg::TIME_BITS-1:0];
            end
            pcc_pkg::REG_FLASH_COUNT: begin
               cfg_in.flash_count = csr_write_data[pcc_pkg::COUNT_BITS-1:0];
            end
            pcc_pkg::REG_BEEP_ON_TIME: begin
               cfg_in.beep_on_time = csr_write_data[pcc_pkg::TIME_BITS-1:0];
            end
            pcc_pkg::REG_BEEP_GAP_TIME: begin
               cfg_in.beep_gap_time = csr_write_data[pcc_pkg::TIME_BITS-1:0];
            end
            pcc_pkg::REG_BEEP_COUNT: begin
               cfg_in.beep_count = csr_write_data[pcc_pkg::COUNT_BITS-1:0];
            end
            pcc_pkg::REG_HOLD_TIME: begin
               cfg_in.hold_time = csr_write_data[pcc_pkg::TIME_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transition_time <= pcc_pkg::TIME_BITS'(750);
         cfg_ff.amber_time      <= pcc_pkg::TIME_BITS'(2000);
         cfg_ff.flash_half_time <= pcc_pkg::TIME_BITS'(500);
         cfg_ff.flash_count     <= pcc_pkg::COUNT_BITS'(10);
         cfg_ff.beep_on_time    <= pcc_pkg::TIME_BITS'(20);
         cfg_ff.beep_gap_time   <= pcc_pkg::TIME_BITS'(100);
         cfg_ff.beep_count      <= pcc_pkg::COUNT_BITS'(100);
         cfg_ff.hold_time       <= pcc_pkg::TIME_BITS'(10000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/pcc_seq.sv @@
// ----------------------------------------------------------------------------
// pcc_seq
// Crossing phase sequencer: button tracking, phase timer, repeat counter
// and lamp decode for one tick.
// ----------------------------------------------------------------------------
module pcc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                button,
   input  pcc_pkg::cfg_type    cfg,
   output pcc_pkg::lamps_type  lamps
);

   localparam int TB     = pcc_pkg::TIMER_BITS;
   localparam int RB     = pcc_pkg::REPEAT_BITS;
   localparam int TCMP_W = ((TB > pcc_pkg::TIME_BITS) ? TB : pcc_pkg::TIME_BITS) + 1;
   localparam int RCMP_W = ((RB > pcc_pkg::COUNT_BITS) ? RB : pcc_pkg::COUNT_BITS) + 1;
   localparam logic [TCMP_W-1:0] TICK_MAX = TCMP_W'({TB{1'b1}});
   localparam logic [RCMP_W-1:0] REP_MAX  = RCMP_W'({RB{1'b1}});

   pcc_pkg::phase_type phase_ff, phase_in, phase_a;
   logic [TB-1:0]      tick_ff, tick_in;
   logic [RB-1:0]      rep_ff, rep_in;
   logic               held_ff, held_in;
   logic               wait_ff, wait_in, wait_a;
   logic               half_ff, half_in;

   logic                          released;
   logic [pcc_pkg::TIME_BITS-1:0] dur;
   logic [pcc_pkg::COUNT_BITS-1:0] cnt;
   logic [TCMP_W-1:0]             tick_next;
   logic [RCMP_W-1:0]             rep_next;
   logic                          tdone;
   logic                          rdone;
   logic                          enter;
   pcc_pkg::phase_type            enter_phase;

   // button handling ahead of the phase step
   always_comb begin
      released = held_ff & ~button;
      phase_a  = phase_ff;
      wait_a   = wait_ff;
      if (phase_ff == pcc_pkg::PH_REST) begin
         if (button) begin
            wait_a = 1'b1;
         end else if (released) begin
            phase_a = pcc_pkg::PH_GREEN_OFF;
         end
      end else if (phase_ff == pcc_pkg::PH_HOLD) begin
         if (released) begin
            wait_a = 1'b1;
         end
      end
   end

   // lamp decode
   always_comb begin
      lamps                = '0;
      lamps.wait_lamp      = wait_a;
      lamps.phase_now      = phase_a;
      unique case (phase_a)
         pcc_pkg::PH_REST: begin
            lamps.green_lamp     = 1'b1;
            lamps.dont_walk_lamp = 1'b1;
         end
         pcc_pkg::PH_GREEN_OFF, pcc_pkg::PH_GAP: begin
            lamps.dont_walk_lamp = 1'b1;
         end
         pcc_pkg::PH_AMBER, pcc_pkg::PH_CLEAR_A, pcc_pkg::PH_CLEAR_B: begin
            lamps.amber_lamp     = 1'b1;
            lamps.dont_walk_lamp = 1'b1;
         end
         pcc_pkg::PH_RED: begin
            lamps.red_lamp       = 1'b1;
            lamps.dont_walk_lamp = 1'b1;
         end
         pcc_pkg::PH_RED_CLEAR: begin
            lamps.red_lamp = 1'b1;
         end
         pcc_pkg::PH_WALK: begin
            lamps.red_lamp  = 1'b1;
            lamps.walk_lamp = 1'b1;
            lamps.buzzer_on = ~half_ff;
         end
         pcc_pkg::PH_FLASH: begin
            lamps.walk_lamp  = half_ff;
            lamps.amber_lamp = half_ff;
         end
         default: begin
            lamps.green_lamp     = 1'b1;
            lamps.dont_walk_lamp = 1'b1;
         end
      endcase
   end

   // duration and count for the current part
   always_comb begin
      cnt = cfg.beep_count;
      unique case (phase_a)
         pcc_pkg::PH_AMBER: dur = cfg.amber_time;
         pcc_pkg::PH_GREEN_OFF, pcc_pkg::PH_GAP, pcc_pkg::PH_RED,
         pcc_pkg::PH_RED_CLEAR: dur = cfg.transition_time;
         pcc_pkg::PH_WALK: dur = half_ff ? cfg.beep_gap_time : cfg.beep_on_time;
         pcc_pkg::PH_FLASH, pcc_pkg::PH_CLEAR_A,
         pcc_pkg::PH_CLEAR_B: dur = cfg.flash_half_time;
         default: dur = cfg.hold_time;
      endcase
      if (phase_a == pcc_pkg::PH_FLASH) begin
         cnt = cfg.flash_count;
      end
      tick_next = TCMP_W'(tick_ff) + TCMP_W'(1);
      rep_next  = RCMP_W'(rep_ff) + RCMP_W'(1);
      tdone     = (tick_next >= TCMP_W'(dur)) || (tick_next >= TICK_MAX);
      rdone     = (rep_next >= RCMP_W'(cnt)) || (rep_next >= REP_MAX);
   end

   // next state
   always_comb begin
      phase_in    = phase_a;
      wait_in     = wait_a;
      held_in     = button;
      tick_in     = tick_ff;
      rep_in      = rep_ff;
      half_in     = half_ff;
      enter       = 1'b0;
      enter_phase = phase_a;
      if (phase_a != pcc_pkg::PH_REST) begin
         tick_in = tdone ? '0 : tick_next[TB-1:0];
         if (tdone) begin
            unique case (phase_a)
               pcc_pkg::PH_WALK, pcc_pkg::PH_FLASH: begin
                  if (!half_ff) begin
                     half_in = 1'b1;
                  end else if (rdone) begin
                     enter       = 1'b1;
                     enter_phase = (phase_a == pcc_pkg::PH_WALK) ?
                                   pcc_pkg::PH_FLASH : pcc_pkg::PH_CLEAR_A;
                  end else begin
                     half_in = 1'b0;
                     rep_in  = rep_next[RB-1:0];
                  end
               end
               pcc_pkg::PH_GREEN_OFF: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_AMBER;
               end
               pcc_pkg::PH_AMBER: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_GAP;
               end
               pcc_pkg::PH_GAP: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_RED;
               end
               pcc_pkg::PH_RED: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_RED_CLEAR;
               end
               pcc_pkg::PH_RED_CLEAR: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_WALK;
               end
               pcc_pkg::PH_CLEAR_A: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_CLEAR_B;
               end
               pcc_pkg::PH_CLEAR_B: begin
                  enter = 1'b1; enter_phase = pcc_pkg::PH_HOLD;
               end
               default: begin
                  enter       = 1'b1;
                  enter_phase = wait_a ? pcc_pkg::PH_GREEN_OFF : pcc_pkg::PH_REST;
               end
            endcase
         end
      end
      if (enter) begin
         phase_in = enter_phase;
         tick_in  = '0;
         rep_in   = '0;
         half_in  = 1'b0;
         if (enter_phase == pcc_pkg::PH_WALK) begin
            wait_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pcc_pkg::PH_REST;
         tick_ff  <= '0;
         rep_ff   <= '0;
         held_ff  <= 1'b0;
         wait_ff  <= 1'b0;
         half_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         rep_ff   <= rep_in;
         held_ff  <= held_in;
         wait_ff  <= wait_in;
         half_ff  <= half_in;
      end
   end

endmodule

@@ tb/tb_pedestrian_crossing_controller.sv @@
// ----------------------------------------------------------------------------
// tb_pedestrian_crossing_controller
// Self-checking testbench for the pelican-style crossing controller.
// ----------------------------------------------------------------------------
// Each tick request is mirrored into a cycle-level copy of the phase sequencer
// kept inside the testbench. That copy produces the lamp, buzzer, wait and
// phase levels expected for the tick, and each response is checked against
// them in order. Directed tests cover reset values, minimum, zero and maximum
// timings, presses during a crossing and presses queued in the hold. Random
// traffic follows, with the timing registers rewritten between segments and
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_pedestrian_crossing_controller;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TICK_SAT   = (longint'(1) << pcc_pkg::TIMER_BITS) - 1;
   localparam longint REPEAT_SAT = (longint'(1) << pcc_pkg::REPEAT_BITS) - 1;
   localparam int     IDLE_LIMIT = 4000;
   localparam int     SEGMENTS   = 10;
   localparam int     SEG_TICKS  = 140;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic                               req_button;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic                               rsp_green_lamp;
   logic                               rsp_amber_lamp;
   logic                               rsp_red_lamp;
   logic                               rsp_walk_lamp;
   logic                               rsp_dont_walk_lamp;
   logic                               rsp_buzzer_on;
   logic                               rsp_wait_lamp;
   logic [3:0]                         rsp_phase_now;
   logic                               csr_write_enable;
   logic [pcc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [pcc_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   pedestrian_crossing_controller u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_button         (req_button),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_green_lamp     (rsp_green_lamp),
      .rsp_amber_lamp     (rsp_amber_lamp),
      .rsp_red_lamp       (rsp_red_lamp),
      .rsp_walk_lamp      (rsp_walk_lamp),
      .rsp_dont_walk_lamp (rsp_dont_walk_lamp),
      .rsp_buzzer_on      (rsp_buzzer_on),
      .rsp_wait_lamp      (rsp_wait_lamp),
      .rsp_phase_now      (rsp_phase_now),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // sequencer mirror
   pcc_pkg::cfg_type   cfg;
   pcc_pkg::phase_type cur_phase;
   longint             part_ticks;
   longint             reps_done;
   bit                 btn_prev;
   bit                 wait_queued;
   bit                 second_half;

   pcc_pkg::lamps_type expected_lamps[$];
   int                 errors;
   int                 idle_cycles;
   bit                 steady;

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 28);
   end

   function automatic void enter_phase(pcc_pkg::phase_type p);
      cur_phase   = p;
      part_ticks  = 0;
      reps_done   = 0;
      second_half = 0;
      if (p == pcc_pkg::PH_WALK) wait_queued = 0;
   endfunction

   function automatic bit part_ended(longint dur);
      longint nxt;
      nxt = part_ticks + 1;
      if (nxt >= dur || nxt >= TICK_SAT) begin
         part_ticks = 0;
         return 1'b1;
      end
      part_ticks = nxt;
      return 1'b0;
   endfunction

   function automatic bit reps_ended(longint cnt);
      longint nxt;
      nxt = reps_done + 1;
      if (nxt >= cnt || nxt >= REPEAT_SAT) return 1'b1;
      reps_done = nxt;
      return 1'b0;
   endfunction

   function automatic void reset_mirror();
      cfg.transition_time = 16'd750;
      cfg.amber_time      = 16'd2000;
      cfg.flash_half_time = 16'd500;
      cfg.flash_count     = 8'd10;
      cfg.beep_on_time    = 16'd20;
      cfg.beep_gap_time   = 16'd100;
      cfg.beep_count      = 8'd100;
      cfg.hold_time       = 16'd10000;
      btn_prev    = 0;
      wait_queued = 0;
      enter_phase(pcc_pkg::PH_REST);
   endfunction

   function automatic void predict_lamps(bit btn);
      pcc_pkg::lamps_type e;
      bit                 released;
      released = btn_prev && !btn;
      if (cur_phase == pcc_pkg::PH_REST) begin
         if (btn) wait_queued = 1;
         else if (released) enter_phase(pcc_pkg::PH_GREEN_OFF);
      end else if (cur_phase == pcc_pkg::PH_HOLD) begin
         if (released) wait_queued = 1;
      end
      btn_prev = btn;

      e = '0;
      case (cur_phase)
         pcc_pkg::PH_REST: begin
            e.green_lamp     = 1;
            e.dont_walk_lamp = 1;
         end
         pcc_pkg::PH_GREEN_OFF: e.dont_walk_lamp = 1;
         pcc_pkg::PH_AMBER: begin
            e.amber_lamp     = 1;
            e.dont_walk_lamp = 1;
         end
         pcc_pkg::PH_GAP: e.dont_walk_lamp = 1;
         pcc_pkg::PH_RED: begin
            e.red_lamp       = 1;
            e.dont_walk_lamp = 1;
         end
         pcc_pkg::PH_RED_CLEAR: e.red_lamp = 1;
         pcc_pkg::PH_WALK: begin
            e.red_lamp  = 1;
            e.walk_lamp = 1;
            e.buzzer_on = !second_half;
         end
         pcc_pkg::PH_FLASH: begin
            e.walk_lamp  = second_half;
            e.amber_lamp = second_half;
         end
         pcc_pkg::PH_CLEAR_A, pcc_pkg::PH_CLEAR_B: begin
            e.amber_lamp     = 1;
            e.dont_walk_lamp = 1;
         end
         default: begin
            e.green_lamp     = 1;
            e.dont_walk_lamp = 1;
         end
      endcase
      e.wait_lamp = wait_queued;
      e.phase_now = cur_phase;
      expected_lamps.push_back(e);

      case (cur_phase)
         pcc_pkg::PH_REST: ;
         pcc_pkg::PH_GREEN_OFF: begin
            if (part_ended(cfg.transition_time)) enter_phase(pcc_pkg::PH_AMBER);
         end
         pcc_pkg::PH_AMBER: begin
            if (part_ended(cfg.amber_time)) enter_phase(pcc_pkg::PH_GAP);
         end
         pcc_pkg::PH_GAP: begin
            if (part_ended(cfg.transition_time)) enter_phase(pcc_pkg::PH_RED);
         end
         pcc_pkg::PH_RED: begin
            if (part_ended(cfg.transition_time)) enter_phase(pcc_pkg::PH_RED_CLEAR);
         end
         pcc_pkg::PH_RED_CLEAR: begin
            if (part_ended(cfg.transition_time)) enter_phase(pcc_pkg::PH_WALK);
         end
         pcc_pkg::PH_WALK: begin
            if (part_ended(second_half ? cfg.beep_gap_time : cfg.beep_on_time)) begin
               if (!second_half) second_half = 1;
               else if (reps_ended(cfg.beep_count)) enter_phase(pcc_pkg::PH_FLASH);
               else second_half = 0;
            end
         end
         pcc_pkg::PH_FLASH: begin
            if (part_ended(cfg.flash_half_time)) begin
               if (!second_half) second_half = 1;
               else if (reps_ended(cfg.flash_count)) enter_phase(pcc_pkg::PH_CLEAR_A);
               else second_half = 0;
            end
         end
         pcc_pkg::PH_CLEAR_A: begin
            if (part_ended(cfg.flash_half_time)) enter_phase(pcc_pkg::PH_CLEAR_B);
         end
         pcc_pkg::PH_CLEAR_B: begin
            if (part_ended(cfg.flash_half_time)) enter_phase(pcc_pkg::PH_HOLD);
         end
         default: begin
            if (part_ended(cfg.hold_time))
               enter_phase(wait_queued ? pcc_pkg::PH_GREEN_OFF : pcc_pkg::PH_REST);
         end
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_tick(input bit btn);
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_button <= btn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_lamps(btn);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_lamps.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input pcc_pkg::csr_index_type idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         pcc_pkg::REG_TRANSITION_TIME: cfg.transition_time = data;
         pcc_pkg::REG_AMBER_TIME:      cfg.amber_time      = data;
         pcc_pkg::REG_FLASH_HALF_TIME: cfg.flash_half_time = data;
         pcc_pkg::REG_FLASH_COUNT:     cfg.flash_count     = data[7:0];
         pcc_pkg::REG_BEEP_ON_TIME:    cfg.beep_on_time    = data;
         pcc_pkg::REG_BEEP_GAP_TIME:   cfg.beep_gap_time   = data;
         pcc_pkg::REG_BEEP_COUNT:      cfg.beep_count      = data[7:0];
         default:                      cfg.hold_time       = data;
      endcase
      @(negedge clock);
   endtask

   task automatic write_all(input logic [15:0] t, input logic [15:0] c);
      write_reg(pcc_pkg::REG_TRANSITION_TIME, t);
      write_reg(pcc_pkg::REG_AMBER_TIME, t);
      write_reg(pcc_pkg::REG_FLASH_HALF_TIME, t);
      write_reg(pcc_pkg::REG_FLASH_COUNT, c);
      write_reg(pcc_pkg::REG_BEEP_ON_TIME, t);
      write_reg(pcc_pkg::REG_BEEP_GAP_TIME, t);
      write_reg(pcc_pkg::REG_BEEP_COUNT, c);
      write_reg(pcc_pkg::REG_HOLD_TIME, t);
   endtask

   function automatic logic [15:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 16'd0;
      if (r < 12) return 16'($urandom_range(7, 30));
      return 16'($urandom_range(1, 5));
   endfunction

   // upper byte is junk, only the low byte is a count
   function automatic logic [15:0] pick_count();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 4) c = 8'd0;
      else if (r < 12) c = 8'($urandom_range(5, 9));
      else c = 8'($urandom_range(1, 4));
      return {8'($urandom_range(0, 255)), c};
   endfunction

   task automatic test_reset_values();
      repeat (5) send_tick(1'b0);
      repeat (3) send_tick(1'b1);
      send_tick(1'b0);
      repeat (20) send_tick(1'b0);
      drain();
   endtask

   task automatic test_min_timing();
      write_all(16'd1, 16'd1);
      // press in red is ignored
      while (cur_phase != pcc_pkg::PH_FLASH) send_tick(cur_phase == pcc_pkg::PH_RED);
      // held into the hold, released on its last tick
      while (cur_phase != pcc_pkg::PH_HOLD) send_tick(1'b1);
      send_tick(1'b0);
      while (cur_phase != pcc_pkg::PH_HOLD) send_tick(1'b0);
      send_tick(1'b0);
      repeat (2) send_tick(1'b1);
      send_tick(1'b0);
      drain();
   endtask

   task automatic test_zero_timing();
      write_all(16'd0, 16'hA500);
      while (cur_phase != pcc_pkg::PH_HOLD) send_tick(1'b0);
      send_tick(1'b0);
      drain();
   endtask

   task automatic test_max_timing();
      write_all(16'hFFFF, 16'hFFFF);
      repeat (2) send_tick(1'b1);
      repeat (200) send_tick(1'b0);
      drain();
   endtask

   task automatic test_random_traffic();
      bit plan[$];
      int k;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         write_reg(pcc_pkg::REG_TRANSITION_TIME, pick_duration());
         write_reg(pcc_pkg::REG_AMBER_TIME, pick_duration());
         write_reg(pcc_pkg::REG_FLASH_HALF_TIME, pick_duration());
         write_reg(pcc_pkg::REG_FLASH_COUNT, pick_count());
         write_reg(pcc_pkg::REG_BEEP_ON_TIME, pick_duration());
         write_reg(pcc_pkg::REG_BEEP_GAP_TIME, pick_duration());
         write_reg(pcc_pkg::REG_BEEP_COUNT, pick_count());
         write_reg(pcc_pkg::REG_HOLD_TIME, pick_duration());
         steady = (seg == 2);
         for (int n = 0; n < SEG_TICKS; n++) begin
            if (plan.size() == 0) begin
               if ($urandom_range(0, 99) < 85) begin
                  k = $urandom_range(1, 4);
                  repeat (k) plan.push_back(1'b1);
                  k = $urandom_range(1, 20);
                  repeat (k) plan.push_back(1'b0);
               end else begin
                  k = $urandom_range(1, 8);
                  repeat (k) plan.push_back(1'($urandom_range(0, 1)));
               end
            end
            send_tick(plan.pop_front());
            if ($urandom_range(0, 99) == 0) drain();
         end
         steady = 0;
         drain();
      end
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      pcc_pkg::lamps_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lamps.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = expected_lamps.pop_front();
            check_field("green_lamp", e.green_lamp, rsp_green_lamp);
            check_field("amber_lamp", e.amber_lamp, rsp_amber_lamp);
            check_field("red_lamp", e.red_lamp, rsp_red_lamp);
            check_field("walk_lamp", e.walk_lamp, rsp_walk_lamp);
            check_field("dont_walk_lamp", e.dont_walk_lamp, rsp_dont_walk_lamp);
            check_field("buzzer_on", e.buzzer_on, rsp_buzzer_on);
            check_field("wait_lamp", e.wait_lamp, rsp_wait_lamp);
            check_field("phase_now", e.phase_now, rsp_phase_now);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_button       = 1'b0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      errors           = 0;
      idle_cycles      = 0;
      steady           = 0;
      reset_mirror();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_min_timing();
      test_zero_timing();
      test_max_timing();
      test_random_traffic();

      drain();
      repeat (10) @(negedge clock);
      if (errors == 0 && expected_lamps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
